[hw/rtl/hgnt_pkg.sv]
// Shared types, codes and constants for the heightfield normal and triangle generator.
`default_nettype none
package hgnt_pkg;

	localparam int GRID_W     = 11;
	localparam int STEP_W     = 32;
	localparam int HEIGHT_W   = 32;
	localparam int IDX_W      = 20;
	localparam int NRM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int WORD_W     = HEIGHT_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVY = 2'd2;

	localparam logic [GRID_W-1:0] GRID_RST = 11'd2;
	localparam logic [STEP_W-1:0] STEP_RST = 32'd65536;

	localparam logic KIND_NORMAL = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic [14:0] ONE_MAG = 15'd16384;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic                       sample_valid;
	} smp_word_t;

	typedef struct packed {
		logic                    result_kind;
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        second_index;
		logic [IDX_W-1:0]        third_index;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    run_last;
	} res_word_t;

	typedef struct packed {
		logic                       start;
		logic                       vld;
		logic signed [HEIGHT_W-1:0] hl;
		logic signed [HEIGHT_W-1:0] hr;
		logic signed [HEIGHT_W-1:0] hd;
		logic signed [HEIGHT_W-1:0] hu;
		logic                       cen_x;
		logic                       cen_z;
	} nrm_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
	} nrm_rsp_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_TFETCH,
		T_NFETCH,
		T_NSTART,
		T_NCALC,
		T_EMIT
	} top_state_t;

	typedef enum logic [2:0] {
		J_A,
		J_T1,
		J_T2,
		J_B,
		J_C
	} job_t;

	typedef enum logic [3:0] {
		N_IDLE,
		N_MULX,
		N_MULZ,
		N_SHIFT,
		N_SQX,
		N_SQY,
		N_SQZ,
		N_SQE,
		N_SQRT,
		N_DIVI,
		N_DIVL,
		N_DIV,
		N_DONE
	} nrm_state_t;

endpackage
`default_nettype wire

[hw/rtl/heightfield_grid_normals_and_triangles_top.sv]
// Top level: row store, item sequencer, normal unit and result register.
//
// Height samples of an N by N grid enter in raster order on the smp channel
// (smp_valid/smp_stall, smp_data); results leave on the res channel
// (res_valid/res_stall, res_data), a vertex normal or a triangle per word.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets grid_size,
// inv_step_x and inv_step_y; cfg_ready is always high. Writing grid_size
// restarts the raster position at row 0, column 0.
// One sample is taken at a time; smp_stall stays high until every result of
// that sample has been loaded into the output register. A sample on row 0
// frees the input the cycle after it is taken. Each other sample first reads
// the triangle corners if it is not in column 0, then per normal does row
// reads and runs the normal unit, whose 32-step square root and three 15-step
// divides share one compare-subtract. Samples on the last row produce up to
// three normals.
// A stalled result waits in the output register; the sequencer holds until it
// drains. Reset clears counters, ring position, state and valid flags and
// resets the settings; data registers and the row store need no clearing.
`default_nettype none
module heightfield_grid_normals_and_triangles_top #(
	parameter int MAX_GRID = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [hgnt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [hgnt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                smp_valid,
	output logic                                     smp_stall,
	input  wire hgnt_pkg::smp_word_t                 smp_data,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output hgnt_pkg::res_word_t                      res_data
);

	localparam int CW    = (MAX_GRID > 2) ? $clog2(MAX_GRID) : 1;
	localparam int NW    = $clog2(MAX_GRID + 1);
	localparam int EW    = (NW > hgnt_pkg::GRID_W) ? NW : hgnt_pkg::GRID_W;
	localparam int DEPTH = 3 * MAX_GRID;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = hgnt_pkg::IDX_W;

	function automatic logic [AW-1:0] slot_base(input logic [1:0] slot);
		logic [AW-1:0] b;
		case (slot)
			2'd0:    b = '0;
			2'd1:    b = AW'(MAX_GRID);
			default: b = AW'(2 * MAX_GRID);
		endcase
		return b;
	endfunction

	function automatic logic [1:0] slot_prev(input logic [1:0] slot);
		logic [1:0] p;
		case (slot)
			2'd0:    p = 2'd2;
			2'd1:    p = 2'd0;
			default: p = 2'd1;
		endcase
		return p;
	endfunction

	logic [hgnt_pkg::GRID_W-1:0] grid_q;
	logic [hgnt_pkg::STEP_W-1:0] invx_q, invy_q;
	logic [CW-1:0]               col_q, row_q;
	logic [1:0]                  ring_q;

	hgnt_pkg::top_state_t state_q, state_d;
	hgnt_pkg::job_t       job_q, job_d;

	logic [CW-1:0]   r_q, c_q;
	logic [1:0]      cs_q, ps_q, pps_q;
	logic [IW-1:0]   base_q;
	logic            do_b_q, do_c_q, tri_ok_q;
	logic [2:0]      f_q;
	logic [hgnt_pkg::WORD_W-1:0] fw_q [5];
	logic            res_valid_q;
	hgnt_pkg::res_word_t res_q, res_d;

	logic [EW-1:0]   grid_e;
	logic [NW-1:0]   n_w;
	logic            wrap, accept, cfg_we, load;
	logic [CW-1:0]   row_e, col_e;
	logic [1:0]      ring_e;
	logic            row_last, col_last;
	logic [CW-1:0]   col_n, row_n;
	logic [1:0]      ring_n;

	logic [CW-1:0]   vr, vc;
	logic [1:0]      cslot, pslot;
	logic            has_l, has_r, has_d, has_u;
	logic [CW-1:0]   fcol;
	logic [1:0]      fslot;
	logic [AW-1:0]   raddr, waddr;
	logic [hgnt_pkg::WORD_W-1:0] rdata;
	logic [IW-1:0]   i_prev, i_cur;

	logic signed [31:0] hc, hl, hr, hd, hu;
	hgnt_pkg::nrm_req_t nreq;
	hgnt_pkg::nrm_rsp_t nrsp;

	assign grid_e = EW'(grid_q);
	assign n_w    = (grid_e < EW'(2)) ? NW'(2) :
	                (grid_e > EW'(MAX_GRID)) ? NW'(MAX_GRID) : NW'(grid_e);

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = smp_valid && !smp_stall;

	assign wrap   = (NW'(row_q) >= n_w) || (NW'(col_q) >= n_w) || (ring_q > 2'd2);
	assign row_e  = wrap ? '0 : row_q;
	assign col_e  = wrap ? '0 : col_q;
	assign ring_e = wrap ? 2'd0 : ring_q;

	assign row_last = (NW'(row_e) == n_w - NW'(1));
	assign col_last = (NW'(col_e) == n_w - NW'(1));

	always_comb begin
		col_n  = col_e + CW'(1);
		row_n  = row_e;
		ring_n = ring_e;
		if (col_last) begin
			col_n  = '0;
			ring_n = (ring_e == 2'd2) ? 2'd0 : ring_e + 2'd1;
			row_n  = row_last ? '0 : row_e + CW'(1);
		end
	end

	// normal job geometry
	assign vr    = (job_q == hgnt_pkg::J_A) ? r_q - CW'(1) : r_q;
	assign vc    = (job_q == hgnt_pkg::J_B) ? c_q - CW'(1) : c_q;
	assign cslot = (job_q == hgnt_pkg::J_A) ? ps_q : cs_q;
	assign pslot = (job_q == hgnt_pkg::J_A) ? pps_q : ps_q;
	assign has_l = (vc != '0);
	assign has_d = (vr != '0);
	assign has_r = ({1'b0, NW'(vc)} + (NW+1)'(1)) < {1'b0, n_w};
	assign has_u = ({1'b0, NW'(vr)} + (NW+1)'(1)) < {1'b0, n_w};

	always_comb begin
		fslot = cs_q;
		fcol  = c_q;
		if (state_q == hgnt_pkg::T_TFETCH) begin
			case (f_q)
				3'd0: begin
					fslot = ps_q;
					fcol  = c_q - CW'(1);
				end
				3'd1: begin
					fslot = ps_q;
					fcol  = c_q;
				end
				3'd2: begin
					fslot = cs_q;
					fcol  = c_q - CW'(1);
				end
				default: begin
					fslot = cs_q;
					fcol  = c_q;
				end
			endcase
		end else begin
			case (f_q)
				3'd0: begin
					fslot = cslot;
					fcol  = vc;
				end
				3'd1: begin
					fslot = cslot;
					fcol  = has_l ? vc - CW'(1) : vc;
				end
				3'd2: begin
					fslot = cslot;
					fcol  = has_r ? vc + CW'(1) : vc;
				end
				3'd3: begin
					fslot = pslot;
					fcol  = vc;
				end
				default: begin
					fslot = cs_q;
					fcol  = vc;
				end
			endcase
		end
	end

	assign raddr = slot_base(fslot) + AW'(fcol);
	assign waddr = slot_base(ring_e) + AW'(col_e);

	hgnt_ram #(
		.WIDTH(hgnt_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_rows (
		.clk  (clk),
		.we   (accept),
		.waddr(waddr),
		.wdata({smp_data.sample_valid, smp_data.height}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign hc = $signed(fw_q[0][31:0]);
	assign hl = (has_l && fw_q[1][32]) ? $signed(fw_q[1][31:0]) : hc;
	assign hr = (has_r && fw_q[2][32]) ? $signed(fw_q[2][31:0]) : hc;
	assign hd = (has_d && fw_q[3][32]) ? $signed(fw_q[3][31:0]) : hc;
	assign hu = (has_u && fw_q[4][32]) ? $signed(fw_q[4][31:0]) : hc;

	hgnt_norm u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (nreq),
		.inv_x (invx_q),
		.inv_y (invy_q),
		.rsp   (nrsp)
	);

	assign i_prev = base_q - IW'(n_w) + IW'(c_q);
	assign i_cur  = base_q + IW'(c_q);

	// next state
	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		case (state_q)
			hgnt_pkg::T_IDLE: begin
				if (accept) begin
					job_d = hgnt_pkg::J_A;
					if (row_e == '0) begin
						state_d = hgnt_pkg::T_IDLE;
					end else if (col_e != '0) begin
						state_d = hgnt_pkg::T_TFETCH;
					end else begin
						state_d = hgnt_pkg::T_NFETCH;
					end
				end
			end
			hgnt_pkg::T_TFETCH: begin
				if (f_q == 3'd5) begin
					state_d = hgnt_pkg::T_NFETCH;
				end
			end
			hgnt_pkg::T_NFETCH: begin
				if (f_q == 3'd5) begin
					state_d = hgnt_pkg::T_NSTART;
				end
			end
			hgnt_pkg::T_NSTART: state_d = hgnt_pkg::T_NCALC;
			hgnt_pkg::T_NCALC: begin
				if (nrsp.done) begin
					state_d = hgnt_pkg::T_EMIT;
				end
			end
			hgnt_pkg::T_EMIT: begin
				if (load) begin
					case (job_q)
						hgnt_pkg::J_A: begin
							if (tri_ok_q) begin
								job_d   = hgnt_pkg::J_T1;
								state_d = hgnt_pkg::T_EMIT;
							end else if (do_b_q) begin
								job_d   = hgnt_pkg::J_B;
								state_d = hgnt_pkg::T_NFETCH;
							end else begin
								state_d = hgnt_pkg::T_IDLE;
							end
						end
						hgnt_pkg::J_T1: begin
							job_d   = hgnt_pkg::J_T2;
							state_d = hgnt_pkg::T_EMIT;
						end
						hgnt_pkg::J_T2: begin
							job_d   = hgnt_pkg::J_B;
							state_d = do_b_q ? hgnt_pkg::T_NFETCH : hgnt_pkg::T_IDLE;
						end
						hgnt_pkg::J_B: begin
							job_d   = hgnt_pkg::J_C;
							state_d = do_c_q ? hgnt_pkg::T_NFETCH : hgnt_pkg::T_IDLE;
						end
						default: state_d = hgnt_pkg::T_IDLE;
					endcase
				end
			end
			default: state_d = hgnt_pkg::T_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		smp_stall  = (state_q != hgnt_pkg::T_IDLE);
		load       = (state_q == hgnt_pkg::T_EMIT) && (!res_valid_q || !res_stall);
		nreq.start = (state_q == hgnt_pkg::T_NSTART);
		nreq.vld   = fw_q[0][32];
		nreq.hl    = hl;
		nreq.hr    = hr;
		nreq.hd    = hd;
		nreq.hu    = hu;
		nreq.cen_x = has_l && has_r;
		nreq.cen_z = has_d && has_u;

		res_d.result_kind  = hgnt_pkg::KIND_NORMAL;
		res_d.second_index = '0;
		res_d.third_index  = '0;
		res_d.normal_x     = nrsp.nx;
		res_d.normal_y     = nrsp.ny;
		res_d.normal_z     = nrsp.nz;
		case (job_q)
			hgnt_pkg::J_A: begin
				res_d.first_index = i_prev;
				res_d.run_last    = !tri_ok_q && !do_b_q;
			end
			hgnt_pkg::J_T1: begin
				res_d.result_kind  = hgnt_pkg::KIND_TRI;
				res_d.first_index  = i_prev - IW'(1);
				res_d.second_index = i_prev;
				res_d.third_index  = i_cur - IW'(1);
				res_d.normal_x     = '0;
				res_d.normal_y     = '0;
				res_d.normal_z     = '0;
				res_d.run_last     = 1'b0;
			end
			hgnt_pkg::J_T2: begin
				res_d.result_kind  = hgnt_pkg::KIND_TRI;
				res_d.first_index  = i_prev;
				res_d.second_index = i_cur;
				res_d.third_index  = i_cur - IW'(1);
				res_d.normal_x     = '0;
				res_d.normal_y     = '0;
				res_d.normal_z     = '0;
				res_d.run_last     = !do_b_q;
			end
			hgnt_pkg::J_B: begin
				res_d.first_index = i_cur - IW'(1);
				res_d.run_last    = !do_c_q;
			end
			default: begin
				res_d.first_index = i_cur;
				res_d.run_last    = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q      <= hgnt_pkg::GRID_RST;
			invx_q      <= hgnt_pkg::STEP_RST;
			invy_q      <= hgnt_pkg::STEP_RST;
			col_q       <= '0;
			row_q       <= '0;
			ring_q      <= '0;
			state_q     <= hgnt_pkg::T_IDLE;
			job_q       <= hgnt_pkg::J_A;
			f_q         <= '0;
			tri_ok_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			if (cfg_we) begin
				case (cfg_index)
					hgnt_pkg::CFG_GRID: begin
						grid_q <= cfg_data[hgnt_pkg::GRID_W-1:0];
						col_q  <= '0;
						row_q  <= '0;
						ring_q <= '0;
					end
					hgnt_pkg::CFG_INVX: invx_q <= cfg_data;
					hgnt_pkg::CFG_INVY: invy_q <= cfg_data;
					default: begin
					end
				endcase
			end else if (accept) begin
				col_q  <= col_n;
				row_q  <= row_n;
				ring_q <= ring_n;
			end
			if ((state_q == hgnt_pkg::T_TFETCH || state_q == hgnt_pkg::T_NFETCH) &&
			    f_q != 3'd5) begin
				f_q <= f_q + 3'd1;
			end else begin
				f_q <= '0;
			end
			if (accept) begin
				tri_ok_q <= 1'b0;
			end else if (state_q == hgnt_pkg::T_TFETCH && f_q == 3'd5) begin
				tri_ok_q <= fw_q[0][32] && fw_q[1][32] && fw_q[2][32] && rdata[32];
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_q    <= row_e;
			c_q    <= col_e;
			cs_q   <= ring_e;
			ps_q   <= slot_prev(ring_e);
			pps_q  <= slot_prev(slot_prev(ring_e));
			base_q <= IW'(row_e) * IW'(n_w);
			do_b_q <= row_last && (col_e != '0);
			do_c_q <= row_last && col_last;
		end
		if ((state_q == hgnt_pkg::T_TFETCH || state_q == hgnt_pkg::T_NFETCH) &&
		    f_q != 3'd0) begin
			fw_q[f_q - 3'd1] <= rdata;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		nrsp.done |-> state_q == hgnt_pkg::T_NCALC)
		else $error("normal unit finished outside its wait state");

	a_tri_no_normal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == hgnt_pkg::KIND_TRI |->
		res_data.normal_x == '0 && res_data.normal_y == '0 && res_data.normal_z == '0)
		else $error("triangle word carries a normal");

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(col_q) < n_w && NW'(row_q) < n_w)
		else $error("raster position beyond grid");

	a_tri_pair: assert property (@(posedge clk) disable iff (!arst_n)
		load && job_q == hgnt_pkg::J_T1 |=> state_q == hgnt_pkg::T_EMIT && job_q == hgnt_pkg::J_T2)
		else $error("first triangle not followed by its partner");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		nrsp.done |-> nrsp.nx <= hgnt_pkg::ONE_Q14 && nrsp.nx >= -hgnt_pkg::ONE_Q14 &&
		nrsp.nz <= hgnt_pkg::ONE_Q14 && nrsp.nz >= -hgnt_pkg::ONE_Q14)
		else $error("normal component out of range");

endmodule
`default_nettype wire

[hw/rtl/hgnt_ram.sv]
// Generic single write, single read RAM with registered read data.
`default_nettype none
module hgnt_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 3072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/hgnt_norm.sv]
// Iterative normal unit: shared multiplier and one shared compare-subtract for root and divide.
`default_nettype none
module hgnt_norm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire hgnt_pkg::nrm_req_t             req,
	input  wire logic [hgnt_pkg::STEP_W-1:0]    inv_x,
	input  wire logic [hgnt_pkg::STEP_W-1:0]    inv_y,
	output hgnt_pkg::nrm_rsp_t                  rsp
);

	hgnt_pkg::nrm_state_t st_q, st_d;

	logic signed [32:0] dx_q, dz_q;
	logic               cen_x_q, cen_z_q;
	logic [63:0]        ax_q, ay_q, az_q;
	logic [63:0]        prod_q, acc_q;
	logic [63:0]        x_q, res_q, bit_q;
	logic [31:0]        len_q;
	logic [63:0]        rem_q, dsh_q;
	logic [14:0]        quo_q;
	logic [3:0]         stp_q;
	logic [1:0]         cmp_q;
	logic signed [15:0] nx_q, ny_q, nz_q;

	logic [32:0] absdx, absdz;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] cs_a, cs_b, cs_d;
	logic        cs_ge;
	logic [63:0] orv;
	logic [29:0] bsel;
	logic [14:0] qf, mag;
	logic signed [15:0] sval;
	logic        neg;

	assign absdx = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
	assign absdz = dz_q[32] ? (~dz_q + 33'd1) : dz_q;
	assign orv   = ax_q | ay_q | az_q;
	assign mul_p = mul_a * mul_b;
	assign cs_ge = cs_a >= cs_b;
	assign cs_d  = cs_a - cs_b;

	always_comb begin
		case (st_q)
			hgnt_pkg::N_MULX: begin
				mul_a = absdx[31:0];
				mul_b = inv_x;
			end
			hgnt_pkg::N_MULZ: begin
				mul_a = absdz[31:0];
				mul_b = inv_y;
			end
			hgnt_pkg::N_SQX: begin
				mul_a = ax_q[31:0];
				mul_b = ax_q[31:0];
			end
			hgnt_pkg::N_SQY: begin
				mul_a = ay_q[31:0];
				mul_b = ay_q[31:0];
			end
			hgnt_pkg::N_SQZ: begin
				mul_a = az_q[31:0];
				mul_b = az_q[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		case (st_q)
			hgnt_pkg::N_SQRT: begin
				cs_a = x_q;
				cs_b = res_q + bit_q;
			end
			default: begin
				cs_a = rem_q;
				cs_b = dsh_q;
			end
		endcase
	end

	always_comb begin
		case (cmp_q)
			2'd0:    bsel = ax_q[29:0];
			2'd1:    bsel = ay_q[29:0];
			default: bsel = az_q[29:0];
		endcase
		case (cmp_q)
			2'd0:    neg = !dx_q[32] && (dx_q != '0);
			2'd2:    neg = dz_q[32];
			default: neg = 1'b0;
		endcase
		qf   = {quo_q[13:0], cs_ge};
		mag  = (qf > hgnt_pkg::ONE_MAG) ? hgnt_pkg::ONE_MAG : qf;
		sval = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			hgnt_pkg::N_IDLE: begin
				if (req.start) begin
					st_d = req.vld ? hgnt_pkg::N_MULX : hgnt_pkg::N_DONE;
				end
			end
			hgnt_pkg::N_MULX:  st_d = hgnt_pkg::N_MULZ;
			hgnt_pkg::N_MULZ:  st_d = hgnt_pkg::N_SHIFT;
			hgnt_pkg::N_SHIFT: begin
				if (orv[63:30] == '0) begin
					st_d = hgnt_pkg::N_SQX;
				end
			end
			hgnt_pkg::N_SQX:   st_d = hgnt_pkg::N_SQY;
			hgnt_pkg::N_SQY:   st_d = hgnt_pkg::N_SQZ;
			hgnt_pkg::N_SQZ:   st_d = hgnt_pkg::N_SQE;
			hgnt_pkg::N_SQE:   st_d = hgnt_pkg::N_SQRT;
			hgnt_pkg::N_SQRT: begin
				if (bit_q[0]) begin
					st_d = hgnt_pkg::N_DIVI;
				end
			end
			hgnt_pkg::N_DIVI:  st_d = hgnt_pkg::N_DIVL;
			hgnt_pkg::N_DIVL:  st_d = hgnt_pkg::N_DIV;
			hgnt_pkg::N_DIV: begin
				if (stp_q == 4'd14) begin
					st_d = (cmp_q == 2'd2) ? hgnt_pkg::N_DONE : hgnt_pkg::N_DIVL;
				end
			end
			hgnt_pkg::N_DONE:  st_d = hgnt_pkg::N_IDLE;
			default:           st_d = hgnt_pkg::N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hgnt_pkg::N_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			hgnt_pkg::N_IDLE: begin
				dx_q    <= $signed({req.hr[31], req.hr}) - $signed({req.hl[31], req.hl});
				dz_q    <= $signed({req.hu[31], req.hu}) - $signed({req.hd[31], req.hd});
				cen_x_q <= req.cen_x;
				cen_z_q <= req.cen_z;
				if (req.start && !req.vld) begin
					nx_q <= '0;
					ny_q <= hgnt_pkg::ONE_Q14;
					nz_q <= '0;
				end
			end
			hgnt_pkg::N_MULX: begin
				ax_q <= cen_x_q ? (mul_p >> 1) : mul_p;
			end
			hgnt_pkg::N_MULZ: begin
				az_q <= cen_z_q ? (mul_p >> 1) : mul_p;
				ay_q <= 64'h0000_0001_0000_0000;
			end
			hgnt_pkg::N_SHIFT: begin
				if (orv[63:34] != '0) begin
					ax_q <= ax_q >> 4;
					ay_q <= ay_q >> 4;
					az_q <= az_q >> 4;
				end else if (orv[63:30] != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
					az_q <= az_q >> 1;
				end
			end
			hgnt_pkg::N_SQX: prod_q <= mul_p;
			hgnt_pkg::N_SQY: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			hgnt_pkg::N_SQZ: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= mul_p;
			end
			hgnt_pkg::N_SQE: begin
				x_q   <= acc_q + prod_q;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			hgnt_pkg::N_SQRT: begin
				if (cs_ge) begin
					x_q   <= cs_d;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			hgnt_pkg::N_DIVI: begin
				len_q <= (res_q[31:0] == '0) ? 32'd1 : res_q[31:0];
				cmp_q <= 2'd0;
			end
			hgnt_pkg::N_DIVL: begin
				rem_q <= ({34'd0, bsel} << 15) + {32'd0, len_q};
				dsh_q <= {32'd0, len_q} << 15;
				stp_q <= '0;
				quo_q <= '0;
			end
			hgnt_pkg::N_DIV: begin
				if (cs_ge) begin
					rem_q <= cs_d;
				end
				quo_q <= qf;
				dsh_q <= dsh_q >> 1;
				stp_q <= stp_q + 4'd1;
				if (stp_q == 4'd14) begin
					case (cmp_q)
						2'd0:    nx_q <= sval;
						2'd1:    ny_q <= sval;
						default: nz_q <= sval;
					endcase
					cmp_q <= cmp_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (st_q == hgnt_pkg::N_DONE);
	assign rsp.nx   = nx_q;
	assign rsp.ny   = ny_q;
	assign rsp.nz   = nz_q;

endmodule
`default_nettype wire

[sim/heightfield_grid_normals_and_triangles_top_test.sv]
// Testbench for the heightfield normal and triangle generator against a predictor.
`default_nettype none
module heightfield_grid_normals_and_triangles_top_test;

	localparam int MAXG = 1024;
	localparam int IDLE_WAIT = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hgnt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hgnt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic smp_valid = 1'b0;
	logic smp_stall;
	hgnt_pkg::smp_word_t smp_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	hgnt_pkg::res_word_t res_data;

	heightfield_grid_normals_and_triangles_top #(.MAX_GRID(MAXG)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.smp_valid(smp_valid), .smp_stall(smp_stall), .smp_data(smp_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	always #5 clk = ~clk;

	logic [hgnt_pkg::GRID_W-1:0] grid_reg = hgnt_pkg::GRID_RST;
	logic [31:0] inv_x = hgnt_pkg::STEP_RST;
	logic [31:0] inv_y = hgnt_pkg::STEP_RST;
	int unsigned col_pos, row_pos, ring_pos;
	logic [31:0] row_height [3*MAXG];
	logic row_valid [3*MAXG];

	hgnt_pkg::smp_word_t sample_q[$];
	hgnt_pkg::res_word_t result_q[$];
	bit failed = 0;
	bit quiet = 0;
	bit hold_off = 0;
	bit paused = 0;
	int smp_gap = 0;
	int res_gap = 0;
	int idle_cycles = 0;

	function automatic int unsigned grid_n();
		if (grid_reg < 2) return 2;
		if (grid_reg > MAXG) return MAXG;
		return grid_reg;
	endfunction

	function automatic longint stored_h(int unsigned slot, int unsigned c);
		return longint'($signed(row_height[(slot % 3) * MAXG + (c % MAXG)]));
	endfunction

	function automatic bit stored_v(int unsigned slot, int unsigned c);
		return row_valid[(slot % 3) * MAXG + (c % MAXG)];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] slope(longint d, logic [31:0] inv, bit central);
		logic [63:0] m;
		m = (d < 0) ? 64'(-d) : 64'(d);
		m = m * {32'd0, inv};
		return central ? (m >> 1) : m;
	endfunction

	function automatic logic signed [15:0] unit_comp(logic [63:0] b, logic [63:0] len, bit neg);
		logic [63:0] v;
		v = (b * 64'd32768 + len) / (64'd2 * len);
		if (v > 64'd16384) v = 64'd16384;
		return neg ? -16'(v) : 16'(v);
	endfunction

	function automatic hgnt_pkg::res_word_t vertex_normal(int unsigned n, int unsigned vr,
			int unsigned vc, int unsigned cs, int unsigned ps, int unsigned ns);
		hgnt_pkg::res_word_t w;
		longint h, hl, hr, hd, hu, dx, dz;
		bit has_l, has_r, has_d, has_u;
		logic [63:0] ax, ay, az, bx, by, bz, len;
		int s;
		w = '0;
		w.result_kind = hgnt_pkg::KIND_NORMAL;
		w.first_index = hgnt_pkg::IDX_W'(vr * n + vc);
		if (!stored_v(cs, vc)) begin
			w.normal_y = hgnt_pkg::ONE_Q14;
			return w;
		end
		h = stored_h(cs, vc);
		has_l = vc > 0;
		has_r = vc + 1 < n;
		has_d = vr > 0;
		has_u = vr + 1 < n;
		hl = (has_l && stored_v(cs, vc - 1)) ? stored_h(cs, vc - 1) : h;
		hr = (has_r && stored_v(cs, vc + 1)) ? stored_h(cs, vc + 1) : h;
		hd = (has_d && stored_v(ps, vc)) ? stored_h(ps, vc) : h;
		hu = (has_u && stored_v(ns, vc)) ? stored_h(ns, vc) : h;
		dx = hr - hl;
		dz = hu - hd;
		ax = slope(dx, inv_x, has_l && has_r);
		az = slope(dz, inv_y, has_d && has_u);
		ay = 64'd1 << 32;
		s = 0;
		while (((ax | ay | az) >> s) >= (64'd1 << 30)) s++;
		bx = ax >> s;
		by = ay >> s;
		bz = az >> s;
		len = int_sqrt(bx * bx + by * by + bz * bz);
		if (len == 0) len = 1;
		w.normal_x = unit_comp(bx, len, dx > 0);
		w.normal_y = unit_comp(by, len, 1'b0);
		w.normal_z = unit_comp(bz, len, dz < 0);
		return w;
	endfunction

	task automatic predict_sample(hgnt_pkg::smp_word_t in_w);
		int unsigned n, r, c, cs, ps, pps, i0, i2;
		hgnt_pkg::res_word_t outs[$];
		hgnt_pkg::res_word_t t;
		n = grid_n();
		if (row_pos >= n || col_pos >= n || ring_pos > 2) begin
			row_pos = 0;
			col_pos = 0;
			ring_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		cs = ring_pos;
		ps = (ring_pos + 2) % 3;
		pps = (ring_pos + 1) % 3;
		row_height[cs * MAXG + c] = in_w.height;
		row_valid[cs * MAXG + c] = in_w.sample_valid;
		if (r >= 1) outs = {outs, vertex_normal(n, r - 1, c, ps, pps, cs)};
		if (r >= 1 && c >= 1 && stored_v(ps, c - 1) && stored_v(ps, c) &&
				stored_v(cs, c - 1) && stored_v(cs, c)) begin
			i0 = (r - 1) * n + c - 1;
			i2 = r * n + c - 1;
			t = '0;
			t.result_kind = hgnt_pkg::KIND_TRI;
			t.first_index = hgnt_pkg::IDX_W'(i0);
			t.second_index = hgnt_pkg::IDX_W'(i0 + 1);
			t.third_index = hgnt_pkg::IDX_W'(i2);
			outs = {outs, t};
			t.first_index = hgnt_pkg::IDX_W'(i0 + 1);
			t.second_index = hgnt_pkg::IDX_W'(i2 + 1);
			t.third_index = hgnt_pkg::IDX_W'(i2);
			outs = {outs, t};
		end
		if (r == n - 1) begin
			if (c >= 1) outs = {outs, vertex_normal(n, r, c - 1, cs, ps, cs)};
			if (c == n - 1) outs = {outs, vertex_normal(n, r, c, cs, ps, cs)};
		end
		if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
		foreach (outs[i]) result_q = {result_q, outs[i]};
		c++;
		if (c >= n) begin
			c = 0;
			ring_pos = (ring_pos + 1) % 3;
			r++;
			if (r >= n) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
			smp_data <= '0;
			smp_gap = 0;
		end else begin
			if (smp_valid && !smp_stall) predict_sample(smp_data);
			if (smp_valid && smp_stall) begin
				// hold
			end else if (smp_gap > 0) begin
				smp_gap--;
				smp_valid <= 1'b0;
			end else if (!hold_off && sample_q.size() > 0) begin
				smp_valid <= 1'b1;
				smp_data <= sample_q.pop_front();
				if (!quiet && $urandom_range(0, 5) == 0) smp_gap = $urandom_range(1, 12);
			end else
				smp_valid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_gap = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, res_data);
					failed = 1;
				end else begin
					hgnt_pkg::res_word_t e;
					e = result_q.pop_front();
					if (e != res_data) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, res_data);
						failed = 1;
					end
				end
			end
			if (res_gap > 0) begin
				res_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 7) == 0) res_gap = $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		if ((smp_valid && !smp_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [hgnt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hgnt_pkg::CFG_GRID: begin
				grid_reg = val[hgnt_pkg::GRID_W-1:0];
				col_pos = 0;
				row_pos = 0;
				ring_pos = 0;
			end
			hgnt_pkg::CFG_INVX: inv_x = val;
			hgnt_pkg::CFG_INVY: inv_y = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || smp_valid || result_q.size() > 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic add_sample(logic [31:0] h, bit v);
		hgnt_pkg::smp_word_t w;
		w.height = h;
		w.sample_valid = v;
		sample_q = {sample_q, w};
	endtask

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return hgnt_pkg::STEP_RST;
			3: return $urandom_range(1, 32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent, n, cnt;
		int base;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, extreme heights, invalid vertex and neighbours
		add_sample(32'h7FFF_FFFF, 1);
		add_sample(32'h8000_0000, 1);
		add_sample(32'h0000_0000, 1);
		add_sample(32'hFFFF_FFFF, 1);
		add_sample(32'h0001_0000, 0);
		add_sample(32'h7FFF_FFFF, 1);
		add_sample(32'h8000_0000, 1);
		add_sample(32'h0000_0000, 0);
		drain();

		write_reg(hgnt_pkg::CFG_GRID, 3);
		write_reg(hgnt_pkg::CFG_INVX, 32'd0);
		write_reg(hgnt_pkg::CFG_INVY, 32'hFFFF_FFFF);
		for (int i = 0; i < 9; i++)
			add_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i != 4);
		drain();

		// out-of-range sizes saturate; a size write mid-grid restarts the raster
		write_reg(hgnt_pkg::CFG_GRID, 11'h7FF);
		add_sample(32'h1234_5678, 1);
		add_sample(32'h8765_4321, 1);
		drain();
		write_reg(hgnt_pkg::CFG_GRID, 0);
		write_reg(hgnt_pkg::CFG_INVX, 32'hFFFF_FFFF);
		write_reg(hgnt_pkg::CFG_INVY, 32'd0);
		for (int i = 0; i < 4; i++) add_sample($urandom, 1);
		drain();
		write_reg(hgnt_pkg::CFG_GRID, 1);
		for (int i = 0; i < 4; i++) add_sample($urandom, 1);
		drain();

		sent = 27;
		while (sent < 430) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : $urandom_range(2, 5);
			write_reg(hgnt_pkg::CFG_INVX, pick_step());
			write_reg(hgnt_pkg::CFG_INVY, pick_step());
			write_reg(hgnt_pkg::CFG_GRID, n);
			if (sent > 360) quiet = 1;
			cnt = n * n * $urandom_range(1, 2);
			if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, n * n);
			if (cnt > 440 - sent) cnt = 440 - sent;
			base = $urandom_range(0, 65535) - 32768;
			for (int i = 0; i < cnt; i++) begin
				if ($urandom_range(0, 4) == 0)
					add_sample($urandom, $urandom_range(0, 3) != 0);
				else
					add_sample(32'(base + $urandom_range(0, 1 << 18) - (1 << 17)) << 8,
						$urandom_range(0, 9) != 0);
			end
			sent += cnt;
			if (!paused && sent > 200) begin
				paused = 1;
				repeat (30) @(posedge clk);
				hold_off = 1;
				while (result_q.size() > 0 || smp_valid) @(posedge clk);
				hold_off = 0;
			end
			drain();
		end

		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/hgnt_pkg.sv
hw/rtl/hgnt_ram.sv
hw/rtl/hgnt_norm.sv
hw/rtl/heightfield_grid_normals_and_triangles_top.sv
sim/heightfield_grid_normals_and_triangles_top_test.sv
